[rtl/core/sea_pkg.sv]
`default_nettype none

package sea_pkg;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 4096;
	localparam int DIST_BITS = 16;
	localparam int ENERGY_BITS = 32;

	localparam int ROWS_REG_BITS = 11;
	localparam int COLS_REG_BITS = 13;
	localparam int ROWS_RESET = 1024;
	localparam int COLS_RESET = 4096;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = COLS_REG_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_ROWS = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_COLS = 1'd1;

	typedef struct packed {
		logic first_entry;
		logic last_row;
		logic last_col;
	} pos_flags_t;

endpackage

`default_nettype wire

[rtl/core/sea_if.sv]
`default_nettype none

interface sea_sample_if #(
	parameter int DIST_BITS = sea_pkg::DIST_BITS
);
	logic                        valid;
	logic                        ready;
	logic signed [DIST_BITS-1:0] distance_sample;

	modport source (output valid, output distance_sample, input ready);
	modport sink (input valid, input distance_sample, output ready);
endinterface

interface sea_energy_if #(
	parameter int ENERGY_BITS = sea_pkg::ENERGY_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [ENERGY_BITS-1:0] energy_value;
	logic                          column_end;
	logic                          image_end;

	modport source (output valid, output energy_value, output column_end, output image_end,
		input ready);
	modport sink (input valid, input energy_value, input column_end, input image_end,
		output ready);
endinterface

interface sea_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [sea_pkg::CFG_INDEX_BITS-1:0]   index;
	logic [sea_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/sea_seq.sv]
`default_nettype none

module sea_seq #(
	parameter int MAX_ROWS = sea_pkg::MAX_ROWS,
	parameter int MAX_COLS = sea_pkg::MAX_COLS,
	localparam int RW = $clog2(MAX_ROWS)
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	sea_cfg_if.sink                  cfg,
	input wire logic                 advance,
	output logic [RW-1:0]            row,
	output logic                     bank,
	output sea_pkg::pos_flags_t      flags
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int XW = 32;
	localparam int ROWS_RST = (sea_pkg::ROWS_RESET < MAX_ROWS) ? sea_pkg::ROWS_RESET : MAX_ROWS;
	localparam int COLS_RST = (sea_pkg::COLS_RESET < MAX_COLS) ? sea_pkg::COLS_RESET : MAX_COLS;
	localparam logic [RW-1:0] ROWS_LAST_RST = RW'(ROWS_RST - 1);
	localparam logic [CW-1:0] COLS_LAST_RST = CW'(COLS_RST - 1);

	logic [RW-1:0] rows_last_q;
	logic [CW-1:0] cols_last_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          bank_q;
	logic [XW-1:0] rows_req;
	logic [XW-1:0] cols_req;
	logic [RW-1:0] rows_last_d;
	logic [CW-1:0] cols_last_d;

	assign cfg.ready = 1'b1;

	always_comb begin
		rows_req = XW'(cfg.data[sea_pkg::ROWS_REG_BITS-1:0]);
		cols_req = XW'(cfg.data[sea_pkg::COLS_REG_BITS-1:0]);
		priority if (rows_req < XW'(2)) begin
			rows_last_d = RW'(1);
		end else if (rows_req > XW'(MAX_ROWS)) begin
			rows_last_d = RW'(MAX_ROWS - 1);
		end else begin
			rows_last_d = RW'(rows_req - XW'(1));
		end
		priority if (cols_req == '0) begin
			cols_last_d = '0;
		end else if (cols_req > XW'(MAX_COLS)) begin
			cols_last_d = CW'(MAX_COLS - 1);
		end else begin
			cols_last_d = CW'(cols_req - XW'(1));
		end
	end

	assign flags.first_entry = (row_q == '0) || (col_q == '0);
	assign flags.last_row    = row_q >= rows_last_q;
	assign flags.last_col    = col_q >= cols_last_q;
	assign row  = row_q;
	assign bank = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_last_q <= ROWS_LAST_RST;
			cols_last_q <= COLS_LAST_RST;
			row_q       <= '0;
			col_q       <= '0;
			bank_q      <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					sea_pkg::REG_IMAGE_ROWS: rows_last_q <= rows_last_d;
					sea_pkg::REG_IMAGE_COLS: cols_last_q <= cols_last_d;
				endcase
			end
			if (advance) begin
				if (flags.last_row) begin
					row_q  <= '0;
					bank_q <= ~bank_q;
					col_q  <= flags.last_col ? '0 : col_q + CW'(1);
				end else begin
					row_q <= row_q + RW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/sea_bank_mem.sv]
`default_nettype none

module sea_bank_mem #(
	parameter int MAX_ROWS = sea_pkg::MAX_ROWS,
	parameter int ENERGY_BITS = sea_pkg::ENERGY_BITS,
	localparam int AW = $clog2(MAX_ROWS) + 1
) (
	input wire logic                          clk,
	input wire logic                          rd_en,
	input wire logic [AW-1:0]                 rd_addr,
	input wire logic                          wr_en,
	input wire logic [AW-1:0]                 wr_addr,
	input wire logic signed [ENERGY_BITS-1:0] wr_data,
	output logic signed [ENERGY_BITS-1:0]     rd_data
);

	logic signed [ENERGY_BITS-1:0] mem_q [2**AW];
	logic signed [ENERGY_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[rtl/core/sea_calc.sv]
`default_nettype none

module sea_calc #(
	parameter int MAX_ROWS = sea_pkg::MAX_ROWS,
	localparam int DIST_BITS = sea_pkg::DIST_BITS,
	localparam int ENERGY_BITS = sea_pkg::ENERGY_BITS,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int AW = RW + 1
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	sea_sample_if.sink                        sample,
	sea_energy_if.source                      energy,
	input wire logic [RW-1:0]                 row,
	input wire logic                          bank,
	input wire sea_pkg::pos_flags_t           flags,
	input wire logic signed [ENERGY_BITS-1:0] rd_data,
	output logic                              accept,
	output logic [AW-1:0]                     rd_addr,
	output logic                              wr_en,
	output logic [AW-1:0]                     wr_addr,
	output logic signed [ENERGY_BITS-1:0]     wr_data
);

	localparam int SW = ((ENERGY_BITS > DIST_BITS + 1) ? ENERGY_BITS : DIST_BITS + 1) + 1;

	logic                          v_s1;
	logic                          v_s2;
	logic                          out_v_q;
	logic signed [DIST_BITS-1:0]   dist_s1;
	logic signed [DIST_BITS-1:0]   dist_s2;
	logic [RW-1:0]                 row_s1;
	logic [RW-1:0]                 row_s2;
	sea_pkg::pos_flags_t           flags_s1;
	sea_pkg::pos_flags_t           flags_s2;
	logic                          bank_s1;
	logic                          bank_s2;
	logic signed [ENERGY_BITS-1:0] min_s2;
	logic signed [ENERGY_BITS-1:0] win_m1_q;
	logic signed [ENERGY_BITS-1:0] win_0_q;
	logic signed [ENERGY_BITS-1:0] zero_q [2];
	logic signed [ENERGY_BITS-1:0] p1;
	logic signed [ENERGY_BITS-1:0] min_d;
	logic signed [ENERGY_BITS-1:0] energy_d;
	logic [AW-1:0]                 need_addr;
	logic                          out_free;
	logic                          adv_s1;
	logic                          adv_s2;
	logic signed [SW-1:0]          dist_ext;
	logic signed [SW-1:0]          sum;
	logic [SW-ENERGY_BITS:0]       upper;
	logic signed [ENERGY_BITS-1:0] out_energy_q;
	logic                          out_col_q;
	logic                          out_img_q;

	assign out_free     = !out_v_q || energy.ready;
	assign adv_s2       = v_s2 && out_free;
	assign adv_s1       = v_s1 && (!v_s2 || adv_s2);
	assign sample.ready = !v_s1 || adv_s1;
	assign accept       = sample.valid && sample.ready;

	// fetch the next row of the previous column
	assign rd_addr   = {~bank, row + RW'(1)};
	assign need_addr = {~bank_s1, row_s1 + RW'(1)};

	assign wr_en   = v_s2;
	assign wr_addr = {bank_s2, row_s2};
	assign wr_data = energy_d;

	// forward an energy still in flight
	assign p1 = (v_s2 && (wr_addr == need_addr)) ? energy_d : rd_data;

	always_comb begin
		min_d = (win_m1_q < win_0_q) ? win_m1_q : win_0_q;
		if (!flags_s1.last_row && (p1 < min_d)) begin
			min_d = p1;
		end
	end

	always_comb begin
		dist_ext = SW'(dist_s2);
		sum      = flags_s2.first_entry ? dist_ext : dist_ext + dist_ext + SW'(min_s2);
		upper    = sum[SW-1:ENERGY_BITS-1];
		if ((&upper) || !(|upper)) begin
			energy_d = sum[ENERGY_BITS-1:0];
		end else if (sum[SW-1]) begin
			energy_d = {1'b1, {(ENERGY_BITS-1){1'b0}}};
		end else begin
			energy_d = {1'b0, {(ENERGY_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (sample.ready) begin
				v_s1 <= sample.valid;
			end
			if (!v_s2 || adv_s2) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dist_s1  <= sample.distance_sample;
			row_s1   <= row;
			flags_s1 <= flags;
			bank_s1  <= bank;
		end
		if (adv_s1) begin
			dist_s2  <= dist_s1;
			row_s2   <= row_s1;
			flags_s2 <= flags_s1;
			bank_s2  <= bank_s1;
			min_s2   <= min_d;
			win_m1_q <= (row_s1 == '0) ? zero_q[~bank_s1] : win_0_q;
			win_0_q  <= p1;
		end
		if (v_s2 && (row_s2 == '0)) begin
			zero_q[bank_s2] <= energy_d;
		end
		if (adv_s2) begin
			out_energy_q <= energy_d;
			out_col_q    <= flags_s2.last_row;
			out_img_q    <= flags_s2.last_row && flags_s2.last_col;
		end
	end

	assign energy.valid        = out_v_q;
	assign energy.energy_value = out_energy_q;
	assign energy.column_end   = out_col_q;
	assign energy.image_end    = out_img_q;

endmodule

`default_nettype wire

[rtl/core/seam_energy_accumulator_unit.sv]
// Cumulative seam energy over a column-major stream of signed distance words: one energy word
// out per sample word in, one word per clock unless the output stalls, each sample passing
// through the s1 and s2 registers to the output register. The rate is set by the column store
// (2 x MAX_ROWS entries, one read port and one write port): each sample reads one energy of the
// previous column and writes one of the current column, and a two-entry window with
// forwarding supplies the other two neighbors. The store needs no clearing after reset. The
// output register lets the input keep flowing while a finished word waits, until s1 and s2
// fill. Registers: index 0 sets the row count (clamped to 2..MAX_ROWS), index 1 the column
// count (clamped to 1..MAX_COLS); write them only while the block is idle. Growing the row
// count mid-image yields undefined energies for the rows that the previous column never had.
`default_nettype none

module seam_energy_accumulator_unit #(
	parameter int MAX_ROWS = sea_pkg::MAX_ROWS,
	parameter int MAX_COLS = sea_pkg::MAX_COLS
) (
	input wire logic     clk,
	input wire logic     arst_n,
	sea_sample_if.sink   sample,
	sea_energy_if.source energy,
	sea_cfg_if.sink      cfg
);

	localparam int ENERGY_BITS = sea_pkg::ENERGY_BITS;
	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = RW + 1;

	logic                          accept;
	logic [RW-1:0]                 row;
	logic                          bank;
	sea_pkg::pos_flags_t           flags;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic signed [ENERGY_BITS-1:0] wr_data;
	logic signed [ENERGY_BITS-1:0] rd_data;

	sea_seq #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (accept),
		.row     (row),
		.bank    (bank),
		.flags   (flags)
	);

	sea_bank_mem #(
		.MAX_ROWS    (MAX_ROWS),
		.ENERGY_BITS (ENERGY_BITS)
	) u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	sea_calc #(
		.MAX_ROWS (MAX_ROWS)
	) u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample),
		.energy  (energy),
		.row     (row),
		.bank    (bank),
		.flags   (flags),
		.rd_data (rd_data),
		.accept  (accept),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

`default_nettype wire

[rtl/core/sea_checker.sv]
`default_nettype none

module sea_checker #(
	parameter int ENERGY_BITS = sea_pkg::ENERGY_BITS
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [ENERGY_BITS-1:0] energy_value,
	input wire logic                   column_end,
	input wire logic                   image_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(energy_value) && $stable(column_end)
			&& $stable(image_end))
		else $error("output word changed while stalled");

	a_image_end_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> column_end)
		else $error("image end without column end");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind seam_energy_accumulator_unit sea_checker #(
	.ENERGY_BITS (ENERGY_BITS)
) u_sea_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (energy.valid),
	.out_ready    (energy.ready),
	.energy_value (energy.energy_value),
	.column_end   (energy.column_end),
	.image_end    (energy.image_end)
);

`default_nettype wire
